// ===== rtl/mvpt_pkg.sv =====
// package for the perspective matrix-vector transform core
// shared widths, register reset values and the divider sideband type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mvpt_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = DATA_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int Q_W       = DATA_W + 1;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int LANES     = 3;

    localparam logic [DATA_W-1:0] REG_RESET [NUM_REGS] = '{
        32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h1000_0000
    };

    typedef struct packed {
        logic neg;
        logic big;
        logic wzero;
    } div_side_t;

endpackage

`default_nettype wire

// ===== rtl/mvpt_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
// depends on mvpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvpt_div import mvpt_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [ACC_W-1:0] rem_in,
    input  wire logic [Q_W-1:0]   nlo_in,
    input  wire logic [ACC_W-1:0] den_in,
    input  wire div_side_t        side_in,
    output logic      [Q_W-1:0]   quo_out,
    output div_side_t             side_out
);

    logic [ACC_W-1:0] rem_reg  [Q_W];
    logic [Q_W-1:0]   nlo_reg  [Q_W];
    logic [ACC_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    div_side_t        side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [ACC_W-1:0] rem_i;
        logic [Q_W-1:0]   nlo_i;
        logic [ACC_W-1:0] den_i;
        logic [Q_W-1:0]   quo_i;
        div_side_t        side_i;
        logic [ACC_W:0]   shifted;
        logic [ACC_W+1:0] diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_i  = rem_in;
            assign nlo_i  = nlo_in;
            assign den_i  = den_in;
            assign quo_i  = '0;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign nlo_i  = nlo_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign quo_i  = quo_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign shifted = {rem_i, nlo_i[Q_W-1]};
        assign diff    = {1'b0, shifted} - {2'b00, den_i};
        assign ge      = ~diff[ACC_W+1];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[ACC_W-1:0] : shifted[ACC_W-1:0];
                nlo_reg[k]  <= {nlo_i[Q_W-2:0], 1'b0};
                den_reg[k]  <= den_i;
                quo_reg[k]  <= {quo_i[Q_W-2:0], ge};
                side_reg[k] <= side_i;
            end
        end
    end

    assign quo_out  = quo_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/matrix_vector_perspective_transform_core.sv =====
// top level of the perspective 4x4 matrix-vector transform core
// depends on mvpt_pkg and mvpt_div
//
// usage:
//   s_ channel carries one point per transfer: x, y, z in signed fixed point.
//   the point is multiplied as a row vector with w = 1 by the 4x4 matrix held
//   in eight configuration registers written through cfg_we/cfg_addr/cfg_wdata.
//   x', y', z' are divided by w (truncated toward zero) unless w is zero,
//   in which case they pass through rescaled and m_tuser[0] is set.
//   results clamp to the 32-bit range; m_tuser[1] reports any clamp.
//   the path from input transfer to m_tvalid runs through the input register,
//   multiply, sum, sign/magnitude prep, 33 divider stages and output register.
//   throughput: one point per cycle; the divider is a 33-stage pipeline
//   with one quotient bit per stage and all stages advance together.
//   when m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
//   reset clears all valid bits and loads the identity matrix.
//   configuration may be written only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_perspective_transform_core import mvpt_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS  = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_addr,
    input  wire logic [DATA_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [3*DATA_W-1:0]   s_tdata,   // in_x, in_y, in_z
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [3*DATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
    output logic      [1:0]            m_tuser    // w_was_zero, saturated
);

    localparam int FRONT = 4;
    localparam int DEPTH = FRONT + Q_W;
    localparam logic [ACC_W-1:0] ZERO_W_DEN =
        ACC_W'(1) << (COORD_FRAC_BITS + COEF_FRAC_BITS);

    logic                     en;
    logic [DATA_W-1:0]        cfg_reg [NUM_REGS];
    logic [DEPTH-1:0]         vld_reg;
    logic signed [DATA_W-1:0] pt_reg [LANES];
    logic signed [COEF_W-1:0] coef [4][4];
    logic signed [PROD_W-1:0] prod_reg [LANES][4];
    logic signed [ACC_W-1:0]  trans_reg [4];
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic [ACC_W-1:0]         rem0_reg [LANES];
    logic [Q_W-1:0]           nlo_reg [LANES];
    logic [ACC_W-1:0]         den_reg;
    div_side_t                side_reg [LANES];
    logic [Q_W-1:0]           quo [LANES];
    div_side_t                dside [LANES];
    logic                     m_tvalid_reg;
    logic [3*DATA_W-1:0]      m_tdata_reg;
    logic [1:0]               m_tuser_reg;
    logic [3*DATA_W-1:0]      m_tdata_next;
    logic [1:0]               m_tuser_next;
    logic                     wz;
    logic [ACC_W-1:0]         wmag;

    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] <= REG_RESET[i];
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = (c % 2 == 1) ? cfg_reg[2*r + c/2][31:16]
                                          : cfg_reg[2*r + c/2][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[DEPTH-1];
        end
    end

    // input, multiply and sum stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                pt_reg[l] <= s_tdata[l*DATA_W +: DATA_W];
            end
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 4; c++) prod_reg[l][c] <= pt_reg[l] * coef[l][c];
            end
            for (int c = 0; c < 4; c++) begin
                trans_reg[c] <= ACC_W'(coef[3][c]) <<< COORD_FRAC_BITS;
                acc_reg[c]   <= ACC_W'(prod_reg[0][c]) + ACC_W'(prod_reg[1][c])
                              + ACC_W'(prod_reg[2][c]) + trans_reg[c];
            end
        end
    end

    // sign, magnitude and range check ahead of the divider
    assign wz   = (acc_reg[3] == '0);
    assign wmag = acc_reg[3][ACC_W-1] ? ACC_W'(-acc_reg[3]) : ACC_W'(acc_reg[3]);

    always_ff @(posedge aclk) begin
        if (en) den_reg <= wz ? ZERO_W_DEN : wmag;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [ACC_W-1:0]     num;
        logic [ACC_W+Q_W-1:0] scaled;
        logic [ACC_W-1:0]     den;
        div_side_t            side;

        assign num    = acc_reg[l][ACC_W-1] ? ACC_W'(-acc_reg[l]) : ACC_W'(acc_reg[l]);
        assign scaled = (ACC_W+Q_W)'(num) << COORD_FRAC_BITS;
        assign den    = wz ? ZERO_W_DEN : wmag;
        assign side.neg   = wz ? acc_reg[l][ACC_W-1]
                               : (acc_reg[l][ACC_W-1] ^ acc_reg[3][ACC_W-1]);
        assign side.big   = scaled >= {den, {Q_W{1'b0}}};
        assign side.wzero = wz;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem0_reg[l] <= scaled[ACC_W+Q_W-1:Q_W];
                nlo_reg[l]  <= scaled[Q_W-1:0];
                side_reg[l] <= side;
            end
        end

        mvpt_div u_div (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem0_reg[l]),
            .nlo_in   (nlo_reg[l]),
            .den_in   (den_reg),
            .side_in  (side_reg[l]),
            .quo_out  (quo[l]),
            .side_out (dside[l])
        );
    end

    // clamp and output register
    always_comb begin
        logic sat;
        sat = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (dside[l].neg) begin
                if (dside[l].big || quo[l] > Q_W'(33'h0_8000_0000)) begin
                    m_tdata_next[l*DATA_W +: DATA_W] = 32'h8000_0000;
                    sat = 1'b1;
                end else begin
                    m_tdata_next[l*DATA_W +: DATA_W] = DATA_W'(-quo[l]);
                end
            end else begin
                if (dside[l].big || quo[l] > Q_W'(33'h0_7FFF_FFFF)) begin
                    m_tdata_next[l*DATA_W +: DATA_W] = 32'h7FFF_FFFF;
                    sat = 1'b1;
                end else begin
                    m_tdata_next[l*DATA_W +: DATA_W] = quo[l][DATA_W-1:0];
                end
            end
        end
        m_tuser_next = {sat, dside[0].wzero};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_zero_w_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[FRONT-1] && side_reg[0].wzero) |-> (den_reg == ZERO_W_DEN))
        else $error("zero w did not select the rescale divisor");

    a_lanes_agree_wzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FRONT-1] |-> (side_reg[0].wzero == side_reg[1].wzero &&
                              side_reg[1].wzero == side_reg[2].wzero))
        else $error("lanes disagree on zero w");

endmodule

`default_nettype wire

// ===== verif/tb_matrix_vector_perspective_transform_core.sv =====
// testbench for the perspective 4x4 matrix-vector transform core
// streams points through a bursty driver, predicts each projected result and checks it
// against the output stream under random and long back-pressure; depends on mvpt_pkg
`timescale 1ns / 1ps

module tb_matrix_vector_perspective_transform_core;
    import mvpt_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [DATA_W-1:0] ox;
        logic [DATA_W-1:0] oy;
        logic [DATA_W-1:0] oz;
        logic              wzero;
        logic              sat;
    } proj_t;

    localparam int DRAIN_CYCLES = 60;
    localparam int COORD_FRAC_BITS_TB = 16;
    localparam int COEF_FRAC_BITS_TB  = 12;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_addr  = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [3*DATA_W-1:0]   s_tdata   = '0;   // in_x, in_y, in_z
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [3*DATA_W-1:0]   m_tdata;          // out_x, out_y, out_z
    logic [1:0]            m_tuser;          // w_was_zero, saturated

    logic [DATA_W-1:0] matrix_regs [NUM_REGS];
    point_t            point_q [$];
    proj_t             proj_q [$];
    int                fail_cnt = 0;
    logic              hold_req = 1'b0;
    logic              hold_done = 1'b0;
    int                hold_cnt = 0;
    int                burst_left = 0;
    int                gap_left = 0;
    int                ready_mode_cnt = 0;
    logic              ready_full = 1'b0;

    matrix_vector_perspective_transform_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic longint coef_of(int row, int col);
        logic [DATA_W-1:0] r;
        r = matrix_regs[row * 2 + col / 2];
        if (col % 2 == 1) return longint'($signed(r[31:16]));
        return longint'($signed(r[15:0]));
    endfunction

    function automatic proj_t project_point(point_t p);
        longint       acc [4];
        longint       px, py, pz;
        logic [63:0]  ma, mw, mq;
        logic [127:0] wide;
        logic         neg, big, wz, sat;
        logic [DATA_W-1:0] lane [3];
        proj_t        r;
        px = longint'($signed(p.x));
        py = longint'($signed(p.y));
        pz = longint'($signed(p.z));
        for (int c = 0; c < 4; c++) begin
            acc[c] = px * coef_of(0, c) + py * coef_of(1, c) + pz * coef_of(2, c)
                   + (coef_of(3, c) <<< COORD_FRAC_BITS_TB);
        end
        wz = (acc[3] == 0);
        sat = 1'b0;
        mw = (acc[3] < 0) ? 64'(-acc[3]) : 64'(acc[3]);
        for (int c = 0; c < 3; c++) begin
            big = 1'b0;
            ma = (acc[c] < 0) ? 64'(-acc[c]) : 64'(acc[c]);
            if (wz) begin
                neg = acc[c] < 0;
                mq = ma >> COEF_FRAC_BITS_TB;
            end else begin
                neg = (acc[c] < 0) != (acc[3] < 0);
                if (ma / mw > 64'hFFFF_FFFF) begin
                    big = 1'b1;
                    mq = '0;
                end else begin
                    wide = ({64'b0, ma} << COORD_FRAC_BITS_TB) / {64'b0, mw};
                    mq = wide[63:0];
                end
            end
            if (neg) begin
                if (big || mq > 64'h8000_0000) begin
                    sat = 1'b1;
                    lane[c] = 32'h8000_0000;
                end else begin
                    lane[c] = 32'(-mq);
                end
            end else begin
                if (big || mq > 64'h7FFF_FFFF) begin
                    sat = 1'b1;
                    lane[c] = 32'h7FFF_FFFF;
                end else begin
                    lane[c] = mq[31:0];
                end
            end
        end
        r.ox = lane[0];
        r.oy = lane[1];
        r.oz = lane[2];
        r.wzero = wz;
        r.sat = sat;
        return r;
    endfunction

    // driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                proj_q.push_back(project_point(point_t'(
                    {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]})));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (point_q.size() > 0) begin
                    point_t p;
                    p = point_q.pop_front();
                    s_tdata  <= {p.z, p.y, p.x};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: randomly chosen full-ready and random stall stretches, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= 300;
            m_tready  <= 1'b0;
        end else begin
            if (ready_mode_cnt == 0) begin
                ready_mode_cnt <= $urandom_range(10, 80);
                ready_full     <= $urandom_range(0, 2) == 0;
            end else begin
                ready_mode_cnt <= ready_mode_cnt - 1;
            end
            m_tready <= ready_full || ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (proj_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                proj_t e;
                e = proj_q.pop_front();
                if (m_tdata[31:0] !== e.ox) begin
                    $error("out_x expected %h actual %h", e.ox, m_tdata[31:0]);
                    fail_cnt++;
                end
                if (m_tdata[63:32] !== e.oy) begin
                    $error("out_y expected %h actual %h", e.oy, m_tdata[63:32]);
                    fail_cnt++;
                end
                if (m_tdata[95:64] !== e.oz) begin
                    $error("out_z expected %h actual %h", e.oz, m_tdata[95:64]);
                    fail_cnt++;
                end
                if (m_tuser[0] !== e.wzero) begin
                    $error("w_was_zero expected %b actual %b", e.wzero, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tuser[1] !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, m_tuser[1]);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (point_q.size() != 0 || s_tvalid || proj_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_matrix(logic [DATA_W-1:0] v [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_IDX_W'(i);
            cfg_wdata <= v[i];
            matrix_regs[i] = v[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    task automatic queue_points(int n);
        point_t p;
        for (int i = 0; i < n; i++) begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            point_q.push_back(p);
        end
    endtask

    function automatic logic [15:0] small_coef();
        return 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
    endfunction

    initial begin
        logic [DATA_W-1:0] m [NUM_REGS];
        point_t p;
        for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = REG_RESET[i];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // identity after reset: extremes and small points
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}; point_q.push_back(p);
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}; point_q.push_back(p);
        p = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001}; point_q.push_back(p);
        p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; point_q.push_back(p);
        p = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}; point_q.push_back(p);
        queue_points(5);
        wait_idle();

        // zero w column: undivided path
        m = '{32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
              32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000};
        load_matrix(m);
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678}; point_q.push_back(p);
        p = '{32'h8000_0000, 32'h0000_0FFF, 32'hFFFF_F001}; point_q.push_back(p);
        queue_points(6);
        wait_idle();

        // extreme coefficients
        m = '{32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_7FFF, 32'h8000_8000,
              32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_FFFF, 32'h0001_0000};
        load_matrix(m);
        p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; point_q.push_back(p);
        p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; point_q.push_back(p);
        queue_points(60);
        wait_idle();

        // perspective matrices with small coefficients, one long receiver hold
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) m[i] = {small_coef(), small_coef()};
            m[7][31:16] = 16'h1000 + 16'($urandom_range(0, 16'h0800));
            load_matrix(m);
            queue_points(110);
            if (ph == 1) hold_req = 1'b1;
            wait_idle();
        end

        // fully random registers, then zero w with random rest
        for (int ph = 0; ph < 3; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) m[i] = $urandom();
            if (ph == 2) begin
                m[1][31:16] = 16'h0000; m[3][31:16] = 16'h0000;
                m[5][31:16] = 16'h0000; m[7][31:16] = 16'h0000;
            end
            load_matrix(m);
            queue_points(80);
            wait_idle();
        end

        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== matrix_vector_perspective_transform_core.f =====
rtl/mvpt_pkg.sv
rtl/mvpt_div.sv
rtl/matrix_vector_perspective_transform_core.sv
verif/tb_matrix_vector_perspective_transform_core.sv
